[hw/rtl/led_status_pattern_sequencer_unit_macros.svh]
// Assertion helpers for the LED status pattern sequencer.
// Every check is sampled on the rising clock edge and is off while rst is high.
`ifndef LED_STATUS_PATTERN_SEQUENCER_UNIT_MACROS_SVH
`define LED_STATUS_PATTERN_SEQUENCER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// Checks an implication (or a plain property) on every clock edge.
`define LSPS_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("lsps assertion failed");

// When the first expression holds, the second must hold in the cycle after.
`define LSPS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lsps next-cycle assertion failed");

`else

`define LSPS_ASSERT(label, prop)
`define LSPS_ASSERT_NEXT(label, ante, cons)

`endif

`endif

[hw/rtl/lsps_pkg.sv]
`default_nettype none

package lsps_pkg;

  // Field and register widths
  localparam int CFG_W       = 16;
  localparam int MODE_W      = 4;
  localparam int CFG_IDX_W   = 3;
  localparam int COUNT_W_DEF = 16;

  // Mode codes (request and current mode share this encoding)
  localparam logic [MODE_W-1:0] MODE_OFF        = 4'd0;
  localparam logic [MODE_W-1:0] MODE_POWERUP    = 4'd1;
  localparam logic [MODE_W-1:0] MODE_APCONN     = 4'd2;
  localparam logic [MODE_W-1:0] MODE_FACTORY    = 4'd3;
  localparam logic [MODE_W-1:0] MODE_ROUTER     = 4'd4;
  localparam logic [MODE_W-1:0] MODE_USER       = 4'd5;
  localparam logic [MODE_W-1:0] MODE_SETUP      = 4'd6;
  localparam logic [MODE_W-1:0] MODE_PAIR       = 4'd7;
  localparam logic [MODE_W-1:0] MODE_LOWBATCALL = 4'd8;
  localparam logic [MODE_W-1:0] MODE_PAIRLOWBAT = 4'd9;
  localparam logic [MODE_W-1:0] MODE_NORMALCALL = 4'd10;
  localparam logic [MODE_W-1:0] MODE_FTEST      = 4'd11;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_SHORT    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOWBAT_CALL   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_USER_CONN     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PAIR_MODE     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BLINK_ON      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PAIR_PERIOD   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_LOWBAT_PERIOD = 3'd6;

  // Register reset values
  localparam logic [CFG_W-1:0] RST_HOLD_SHORT    = 16'd20;
  localparam logic [CFG_W-1:0] RST_LOWBAT_CALL   = 16'd30;
  localparam logic [CFG_W-1:0] RST_USER_CONN     = 16'd50;
  localparam logic [CFG_W-1:0] RST_PAIR_MODE     = 16'd600;
  localparam logic [CFG_W-1:0] RST_BLINK_ON      = 16'd2;
  localparam logic [CFG_W-1:0] RST_PAIR_PERIOD   = 16'd10;
  localparam logic [CFG_W-1:0] RST_LOWBAT_PERIOD = 16'd3;

  // Handshake between the sequencer and the remainder unit
  typedef struct packed {
    logic start;
  } mod_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mod_stat_t;

endpackage

`default_nettype wire

[hw/rtl/lsps_mod_unit.sv]
`default_nettype none

// Bit-serial remainder: one restoring subtract step per cycle,
// one step for each dividend bit of a request.
module lsps_mod_unit
  import lsps_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_W_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire mod_ctl_t               ctl,
  input  wire logic [COUNT_WIDTH-1:0] dividend,
  input  wire logic [CFG_W-1:0]       divisor,
  output mod_stat_t                   stat,
  output logic [CFG_W-1:0]            rem
);

  localparam int STEP_W = $clog2(COUNT_WIDTH);

  logic                   busy;
  logic [STEP_W-1:0]      step;
  logic [COUNT_WIDTH-1:0] dvd;
  logic [CFG_W-1:0]       dvs;
  logic [CFG_W:0]         trial;
  logic                   fits;
  logic                   last;

  // Shift in the next dividend bit and try a subtract
  assign trial = {rem, dvd[COUNT_WIDTH-1]};
  assign fits  = (trial >= {1'b0, dvs});
  assign last  = busy && (step == STEP_W'(COUNT_WIDTH - 1));

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (ctl.start) begin
      busy <= 1'b1;
      step <= '0;
    end else if (busy) begin
      busy <= !last;
      step <= step + 1'b1;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      rem <= '0;
      dvd <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      rem <= fits ? CFG_W'(trial - {1'b0, dvs}) : trial[CFG_W-1:0];
      dvd <= {dvd[COUNT_WIDTH-2:0], 1'b0};
    end
  end

  assign stat.busy = busy;
  assign stat.done = last;

endmodule

`default_nettype wire

[hw/rtl/led_status_pattern_sequencer_unit.sv]
`default_nettype none

// LED status pattern sequencer. Each accepted input item is one tick that may
// carry a mode request; each tick yields one result with the LED level and the
// current mode. For each item the request is latched and the mode switched at
// acceptance, then the bit-serial remainder of the tick count by the blink period
// is formed, and finally the mode is evaluated. in_stall is high from
// acceptance until the evaluation is committed. A finished result
// sits in an output register, so the next tick can be accepted while it waits;
// evaluation of that next tick holds only if the previous result is still
// untaken. Configuration writes go through a plain write port and must be made
// while the block is idle.
`include "led_status_pattern_sequencer_unit_macros.svh"

module led_status_pattern_sequencer_unit
  import lsps_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_W_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  // configuration
  input  wire logic                 cfg_write,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  // input tick
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic                 request_valid,
  input  wire logic [MODE_W-1:0]    requested_mode,
  // result
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic                      led_on,
  output logic [MODE_W-1:0]         mode_now
);

  localparam int CMP_W = (COUNT_WIDTH > CFG_W) ? COUNT_WIDTH : CFG_W;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_EVAL = 3'b100
  } state_t;

  state_t state;

  // Configuration registers
  logic [CFG_W-1:0] hold_short_ticks;
  logic [CFG_W-1:0] lowbat_call_ticks;
  logic [CFG_W-1:0] user_connected_ticks;
  logic [CFG_W-1:0] pair_mode_ticks;
  logic [CFG_W-1:0] blink_on_ticks;
  logic [CFG_W-1:0] pair_blink_period;
  logic [CFG_W-1:0] lowbat_blink_period;

  // Sequencer state
  logic                   pending_valid;
  logic [MODE_W-1:0]      pending_mode;
  logic [MODE_W-1:0]      current_mode;
  logic [COUNT_WIDTH-1:0] tick_count;
  logic                   led_level;
  logic                   frozen;

  logic                   accept;
  logic                   out_busy;
  logic                   commit;
  logic                   pend_valid_next;
  logic [MODE_W-1:0]      pend_mode_next;
  logic                   freeze_next;
  logic                   do_switch;
  logic [MODE_W-1:0]      start_mode;
  logic [COUNT_WIDTH-1:0] start_count;

  mod_ctl_t               mod_ctl;
  mod_stat_t              mod_stat;
  logic [CFG_W-1:0]       mod_rem;

  logic [CFG_W-1:0]       blink_period;
  logic [CMP_W-1:0]       count_ext;
  logic [CMP_W-1:0]       count_inc_ext;
  logic [CMP_W-1:0]       phase;
  logic [COUNT_WIDTH-1:0] count_inc;
  logic                   blink;

  logic [MODE_W-1:0]      mode_next;
  logic [COUNT_WIDTH-1:0] count_next;
  logic                   led_next;

  // Blink period used by a mode
  function automatic logic [CFG_W-1:0] period_of(
    input logic [MODE_W-1:0] mode,
    input logic [CFG_W-1:0]  hold_p,
    input logic [CFG_W-1:0]  pair_p,
    input logic [CFG_W-1:0]  lowbat_p
  );
    logic [CFG_W-1:0] p;
    case (mode)
      MODE_SETUP, MODE_PAIR:           p = pair_p;
      MODE_LOWBATCALL, MODE_PAIRLOWBAT: p = lowbat_p;
      default:                         p = hold_p;
    endcase
    return p;
  endfunction

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_busy = out_valid && out_stall;
  assign commit   = (state == S_EVAL) && !out_busy;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_short_ticks     <= RST_HOLD_SHORT;
      lowbat_call_ticks    <= RST_LOWBAT_CALL;
      user_connected_ticks <= RST_USER_CONN;
      pair_mode_ticks      <= RST_PAIR_MODE;
      blink_on_ticks       <= RST_BLINK_ON;
      pair_blink_period    <= RST_PAIR_PERIOD;
      lowbat_blink_period  <= RST_LOWBAT_PERIOD;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_HOLD_SHORT:    hold_short_ticks     <= cfg_data;
        REG_LOWBAT_CALL:   lowbat_call_ticks    <= cfg_data;
        REG_USER_CONN:     user_connected_ticks <= cfg_data;
        REG_PAIR_MODE:     pair_mode_ticks      <= cfg_data;
        REG_BLINK_ON:      blink_on_ticks       <= cfg_data;
        REG_PAIR_PERIOD:   pair_blink_period    <= cfg_data;
        REG_LOWBAT_PERIOD: lowbat_blink_period  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Request latch and mode switch at acceptance
  always_comb begin
    pend_valid_next = pending_valid;
    pend_mode_next  = pending_mode;
    if (request_valid && (requested_mode <= MODE_FTEST)) begin
      pend_valid_next = 1'b1;
      pend_mode_next  = requested_mode;
    end
    freeze_next = pend_valid_next && (pend_mode_next == MODE_FTEST);
    do_switch   = !freeze_next && pend_valid_next && (pend_mode_next != current_mode);
    start_mode  = do_switch ? pend_mode_next : current_mode;
    start_count = do_switch ? '0 : tick_count;
  end

  // Remainder of the tick count by the mode's blink period
  assign mod_ctl.start = accept;

  lsps_mod_unit #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_mod (
    .clk      (clk),
    .rst      (rst),
    .ctl      (mod_ctl),
    .dividend (start_count),
    .divisor  (period_of(start_mode, hold_short_ticks, pair_blink_period,
                         lowbat_blink_period)),
    .stat     (mod_stat),
    .rem      (mod_rem)
  );

  // Mode evaluation
  always_comb begin
    blink_period  = period_of(current_mode, hold_short_ticks, pair_blink_period,
                              lowbat_blink_period);
    count_inc     = tick_count + 1'b1;
    count_ext     = CMP_W'(tick_count);
    count_inc_ext = CMP_W'(count_inc);
    phase         = (blink_period == '0) ? count_ext : CMP_W'(mod_rem);
    blink         = (phase < CMP_W'(blink_on_ticks));

    mode_next  = current_mode;
    count_next = tick_count;
    led_next   = led_level;
    if (!frozen) begin
      case (current_mode)
        MODE_OFF: begin
          led_next = 1'b0;
        end
        MODE_POWERUP, MODE_NORMALCALL: begin
          if (count_ext < CMP_W'(hold_short_ticks)) begin
            led_next   = 1'b1;
            count_next = count_inc;
          end else begin
            mode_next = MODE_OFF;
          end
        end
        MODE_APCONN: begin
          led_next   = blink;
          count_next = count_inc;
        end
        MODE_FACTORY: begin
          led_next = 1'b1;
        end
        MODE_ROUTER, MODE_USER: begin
          if (count_ext <= CMP_W'(user_connected_ticks)) begin
            led_next   = 1'b1;
            count_next = count_inc;
          end else begin
            mode_next = MODE_OFF;
          end
        end
        MODE_SETUP, MODE_PAIR: begin
          led_next   = blink;
          count_next = count_inc;
          if (count_inc_ext >= CMP_W'(pair_mode_ticks)) begin
            mode_next = MODE_OFF;
          end
        end
        MODE_LOWBATCALL, MODE_PAIRLOWBAT: begin
          if ((current_mode == MODE_LOWBATCALL) &&
              (count_ext >= CMP_W'(lowbat_call_ticks))) begin
            mode_next = MODE_OFF;
          end
          led_next   = blink;
          count_next = count_inc;
        end
        default: ;
      endcase
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      pending_valid <= 1'b0;
      pending_mode  <= MODE_OFF;
      current_mode  <= MODE_OFF;
      tick_count    <= '0;
      led_level     <= 1'b0;
      frozen        <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            pending_valid <= do_switch ? 1'b0 : pend_valid_next;
            pending_mode  <= pend_mode_next;
            current_mode  <= start_mode;
            tick_count    <= start_count;
            frozen        <= freeze_next;
            state         <= S_DIV;
          end
        end
        S_DIV: begin
          if (mod_stat.done) begin
            state <= S_EVAL;
          end
        end
        S_EVAL: begin
          if (commit) begin
            current_mode <= mode_next;
            tick_count   <= count_next;
            led_level    <= led_next;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      led_on   <= led_next;
      mode_now <= mode_next;
    end
  end

  // Checks
  `LSPS_ASSERT(a_done_in_div, mod_stat.done |-> (state == S_DIV))
  `LSPS_ASSERT(a_busy_matches_div, mod_stat.busy |-> (state == S_DIV))
  `LSPS_ASSERT(a_mode_legal, out_valid |-> (mode_now <= MODE_FTEST))
  `LSPS_ASSERT_NEXT(a_freeze_holds, commit && frozen,
    out_valid && (mode_now == $past(current_mode)) && (led_on == $past(led_level)))
  `LSPS_ASSERT_NEXT(a_accept_starts_div, accept, (state == S_DIV) && mod_stat.busy)

endmodule

`default_nettype wire
